### design/dtq_pkg.sv
// shared types and codes for the deadline timer queue
`default_nettype none
package dtq_pkg;

    typedef enum logic [1:0] {
        CMD_SET_MODE = 2'd0,
        CMD_START    = 2'd1,
        CMD_CANCEL   = 2'd2,
        CMD_EXPIRE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_STARTED     = 3'd0,
        ST_RESTARTED   = 3'd1,
        ST_REJECTED    = 3'd2,
        ST_CANCEL_IDLE = 3'd3,
        ST_CANCELLED   = 3'd4,
        ST_EXPIRED     = 3'd5,
        ST_CHECK_DONE  = 3'd6,
        ST_MODE_SET    = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        CFG_DELTA_FLOOR = 3'd0,
        CFG_MAX_DELTA   = 3'd1,
        CFG_MULT        = 3'd2,
        CFG_SHIFT       = 3'd3,
        CFG_MAX_IDLE    = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_DELTA,
        S_MUL,
        S_SHIFT,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

### design/deadline_timer_queue_core.sv
// deadline timer queue: slot store, sequential earliest scan and compare value unit
//
// channel  direction  handshake            payload
// s_       in         s_valid / s_ready    command, timer_id, mode, time_value, now
// m_       out        m_valid / m_ready    status, slot, program_valid, compare_cycles, last
// cfg_     in         cfg_valid / cfg_ready cfg_addr, cfg_data
//
// one comparator walks the NUM_TIMERS+1 slots, one slot a cycle, for every scan
// set mode, rejects and idle cancels go straight to the result; start scans once
// cancel of the earliest slot scans twice; programming adds delta, mul and shift steps
// expire check does one scan per expired slot plus one, each result waits for m_ready
// s_ready is high only when idle; a stalled result holds the sequencer
// synchronous active-low reset clears queued marks, modes, order counter and scan flags
`default_nettype none
module deadline_timer_queue_core
    import dtq_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [3:0]  s_timer_id,
    input  wire logic        s_mode,
    input  wire logic [62:0] s_time_value,
    input  wire logic [62:0] s_now,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [4:0]       m_slot,
    output logic             m_program_valid,
    output logic [31:0]      m_compare_cycles,
    output logic             m_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [63:0] cfg_data
);

    localparam int NSLOTS = NUM_TIMERS + 1;
    localparam int SW = $clog2(NSLOTS);
    localparam logic [SW-1:0] REFRESH = SW'(NUM_TIMERS);
    localparam logic [SW-1:0] LAST_IDX = SW'(NSLOTS - 1);

    // configuration
    logic [31:0] delta_floor_reg, max_delta_reg, mult_reg;
    logic [5:0]  shift_reg;
    logic [62:0] max_idle_reg;

    // slot store
    logic [63:0] dl_reg [NSLOTS];
    logic [31:0] stamp_reg [NSLOTS];
    logic [NSLOTS-1:0] queued_reg;
    logic [15:0] mode_reg;
    logic [31:0] order_reg;

    // latched transaction
    cmd_t        cmd_reg;
    logic [3:0]  id_reg;
    logic [62:0] now_reg;
    logic        pass1_reg;
    logic        more_reg;

    // scan
    state_t      state_reg, state_next;
    logic [SW-1:0] idx_reg;
    logic        found_reg;
    logic [SW-1:0] best_reg;
    logic [63:0] best_dl_reg;
    logic [31:0] best_st_reg;

    // compare value path
    logic [31:0] delta_reg;
    logic [63:0] prod_reg;

    // result
    status_t     status_reg;
    logic [4:0]  slot_reg;
    logic        pv_reg;
    logic [31:0] cyc_reg;
    logic        last_reg;

    logic        accept;
    logic [SW-1:0] s_id, id_idx;
    logic        s_id_ok, id_ok;
    logic        better;
    logic [63:0] diff;
    logic [31:0] clamp_hi, clamp_lo;
    logic        is_first;
    logic        due;

    assign s_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept = s_valid && s_ready;
    assign s_id = SW'(s_timer_id);
    assign id_idx = SW'(id_reg);
    assign s_id_ok = {28'd0, s_timer_id} < 32'(NUM_TIMERS);
    assign id_ok = {28'd0, id_reg} < 32'(NUM_TIMERS);

    assign better = queued_reg[idx_reg] && (!found_reg || dl_reg[idx_reg] < best_dl_reg
                    || (dl_reg[idx_reg] == best_dl_reg && stamp_reg[idx_reg] < best_st_reg));
    assign is_first = found_reg && best_reg == id_idx;
    assign due = found_reg && best_dl_reg <= {1'b0, now_reg};

    // clamp: upper first, lower last so the floor wins
    assign diff = best_dl_reg - {1'b0, now_reg};
    always_comb begin
        if (best_dl_reg <= {1'b0, now_reg})
            clamp_hi = delta_floor_reg;
        else if (diff > {32'd0, max_delta_reg})
            clamp_hi = max_delta_reg;
        else
            clamp_hi = diff[31:0];
        clamp_lo = (clamp_hi < delta_floor_reg) ? delta_floor_reg : clamp_hi;
    end

    assign m_valid = (state_reg == S_OUT);
    assign m_status = status_reg;
    assign m_slot = slot_reg;
    assign m_program_valid = pv_reg;
    assign m_compare_cycles = cyc_reg;
    assign m_last = last_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    priority if (s_command == CMD_SET_MODE)
                        state_next = S_OUT;
                    else if (s_command == CMD_START)
                        state_next = (!s_id_ok || mode_reg[s_timer_id] != s_mode ||
                                      (!s_mode && s_time_value <= s_now)) ? S_OUT : S_SCAN;
                    else if (s_command == CMD_CANCEL)
                        state_next = (s_id_ok && queued_reg[s_id]) ? S_SCAN : S_OUT;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN: if (idx_reg == LAST_IDX) state_next = S_EVAL;
            S_EVAL: begin
                unique case (cmd_reg)
                    CMD_START: state_next = is_first ? S_DELTA : S_OUT;
                    CMD_CANCEL: begin
                        if (pass1_reg)
                            state_next = is_first ? S_SCAN : S_OUT;
                        else
                            state_next = found_reg ? S_DELTA : S_OUT;
                    end
                    CMD_EXPIRE: state_next = (due || !found_reg) ? S_OUT : S_DELTA;
                    default: state_next = S_OUT;
                endcase
            end
            S_DELTA: state_next = S_MUL;
            S_MUL:   state_next = S_SHIFT;
            S_SHIFT: state_next = S_OUT;
            S_OUT:   if (m_ready) state_next = more_reg ? S_SCAN : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_floor_reg <= 32'd1000;
            max_delta_reg   <= 32'hFFFF_FFFF;
            mult_reg        <= 32'd1;
            shift_reg       <= 6'd0;
            max_idle_reg    <= 63'd1_000_000_000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_addr)
                CFG_DELTA_FLOOR: delta_floor_reg <= cfg_data[31:0];
                CFG_MAX_DELTA:   max_delta_reg   <= cfg_data[31:0];
                CFG_MULT:        mult_reg        <= cfg_data[31:0];
                CFG_SHIFT:       shift_reg       <= cfg_data[5:0];
                CFG_MAX_IDLE:    max_idle_reg    <= cfg_data[62:0];
                default: ;
            endcase
        end
    end

    // control state: queued marks, modes, order counter, sequencing flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queued_reg <= '0;
            mode_reg   <= '0;
            order_reg  <= 32'd0;
            pass1_reg  <= 1'b0;
            more_reg   <= 1'b0;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    more_reg  <= 1'b0;
                    pass1_reg <= 1'b1;
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    if (accept) begin
                        if (s_command == CMD_SET_MODE && s_id_ok)
                            mode_reg[s_timer_id] <= s_mode;
                        if (s_command == CMD_START && s_id_ok &&
                            mode_reg[s_timer_id] == s_mode &&
                            !(!s_mode && s_time_value <= s_now)) begin
                            queued_reg[s_id] <= 1'b1;
                            order_reg <= order_reg + 32'd1;
                        end
                    end
                end
                S_SCAN: begin
                    if (better) found_reg <= 1'b1;
                    if (idx_reg != LAST_IDX) idx_reg <= idx_reg + SW'(1);
                end
                S_EVAL: begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    unique case (cmd_reg)
                        CMD_CANCEL: begin
                            if (pass1_reg) begin
                                queued_reg[id_idx] <= 1'b0;
                                pass1_reg <= 1'b0;
                            end else if (!found_reg) begin
                                queued_reg[REFRESH] <= 1'b1;
                                order_reg <= order_reg + 32'd1;
                            end
                        end
                        CMD_EXPIRE: begin
                            if (due) begin
                                queued_reg[best_reg] <= 1'b0;
                                more_reg <= 1'b1;
                            end else begin
                                more_reg <= 1'b0;
                                if (!found_reg) begin
                                    queued_reg[REFRESH] <= 1'b1;
                                    order_reg <= order_reg + 32'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // payload: deadlines, stamps, latched inputs, scan best, result
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_reg <= cmd_t'(s_command);
                    id_reg  <= s_timer_id;
                    now_reg <= s_now;
                    slot_reg <= {1'b0, s_timer_id};
                    pv_reg  <= 1'b0;
                    cyc_reg <= 32'd0;
                    last_reg <= 1'b1;
                    priority if (s_command == CMD_SET_MODE)
                        status_reg <= ST_MODE_SET;
                    else if (s_command == CMD_START) begin
                        if (!s_id_ok || mode_reg[s_timer_id] != s_mode ||
                            (!s_mode && s_time_value <= s_now))
                            status_reg <= ST_REJECTED;
                        else begin
                            status_reg <= queued_reg[s_id] ? ST_RESTARTED : ST_STARTED;
                            dl_reg[s_id] <= s_mode ? {1'b0, s_now} + {1'b0, s_time_value}
                                                   : {1'b0, s_time_value};
                            stamp_reg[s_id] <= order_reg;
                        end
                    end else if (s_command == CMD_CANCEL)
                        status_reg <= (s_id_ok && queued_reg[s_id]) ? ST_CANCELLED
                                                                    : ST_CANCEL_IDLE;
                    else
                        status_reg <= ST_CHECK_DONE;
                end
            end
            S_SCAN: begin
                if (better) begin
                    best_reg    <= idx_reg;
                    best_dl_reg <= dl_reg[idx_reg];
                    best_st_reg <= stamp_reg[idx_reg];
                end
            end
            S_EVAL: begin
                if (cmd_reg == CMD_EXPIRE) begin
                    if (due) begin
                        status_reg <= ST_EXPIRED;
                        slot_reg   <= 5'(best_reg);
                        last_reg   <= 1'b0;
                    end else begin
                        status_reg <= ST_CHECK_DONE;
                        slot_reg   <= 5'd0;
                        last_reg   <= 1'b1;
                    end
                end
                if (!found_reg && ((cmd_reg == CMD_EXPIRE && !due) ||
                                   (cmd_reg == CMD_CANCEL && !pass1_reg))) begin
                    // empty queue: arm the refresh slot
                    dl_reg[REFRESH]    <= {1'b0, now_reg} + {1'b0, max_idle_reg};
                    stamp_reg[REFRESH] <= order_reg;
                end
            end
            S_DELTA: delta_reg <= clamp_lo;
            S_MUL:   prod_reg  <= {32'd0, delta_reg} * {32'd0, mult_reg};
            S_SHIFT: begin
                cyc_reg <= 32'(prod_reg >> shift_reg);
                pv_reg  <= 1'b1;
            end
            default: ;
        endcase
    end

    a_scan_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> !s_ready)
        else $error("input taken during scan");

    a_program_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_program_valid) |-> (m_status == ST_STARTED ||
        m_status == ST_RESTARTED || m_status == ST_CANCELLED || m_status == ST_CHECK_DONE))
        else $error("program flag on a status that never programs");

    a_expired_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EXPIRED) |-> (!m_last && !m_program_valid))
        else $error("expired result marked last or programming");

    a_more_only_expire: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && more_reg) |=> (state_reg == S_SCAN))
        else $error("expire loop did not rescan");

endmodule
`default_nettype wire
